>>> design/vmu_pkg.sv
// Shared constants, opcode and status codes for the 3D vector math unit.
`default_nettype none

package vmu_pkg;

  localparam int COMP_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_DOT   = 4'd2,
    OP_CROSS = 4'd3,
    OP_SCALE = 4'd4,
    OP_DIV   = 4'd5,
    OP_MAG   = 4'd6,
    OP_NORM  = 4'd7,
    OP_PROJ  = 4'd8,
    OP_SPROJ = 4'd9
  } vmu_op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } vmu_status_t;

endpackage

`default_nettype wire

>>> design/vmu_if.sv
// Request and response channel interfaces of the vector math unit.
`default_nettype none

interface vmu_req_if import vmu_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [3:0]                   cmd;
  logic signed [COMP_WIDTH-1:0] a_x;
  logic signed [COMP_WIDTH-1:0] a_y;
  logic signed [COMP_WIDTH-1:0] a_z;
  logic signed [COMP_WIDTH-1:0] b_x;
  logic signed [COMP_WIDTH-1:0] b_y;
  logic signed [COMP_WIDTH-1:0] b_z;
  logic signed [COMP_WIDTH-1:0] scalar_in;

  modport source (output valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, input ready);
  modport sink   (input valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, output ready);
endinterface

interface vmu_rsp_if import vmu_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] res_x;
  logic signed [COMP_WIDTH-1:0] res_y;
  logic signed [COMP_WIDTH-1:0] res_z;
  logic signed [COMP_WIDTH-1:0] res_scalar;
  logic [1:0]                   status;

  modport source (output valid, res_x, res_y, res_z, res_scalar, status, input ready);
  modport sink   (input valid, res_x, res_y, res_z, res_scalar, status, output ready);
endinterface

`default_nettype wire

>>> design/vmu_lane.sv
// One component lane: the registered products a component takes part in.
`default_nettype none

module vmu_lane import vmu_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [COMP_WIDTH-1:0]   a,
  input  logic signed [COMP_WIDTH-1:0]   b,
  input  logic signed [COMP_WIDTH-1:0]   a_n1,
  input  logic signed [COMP_WIDTH-1:0]   b_n1,
  input  logic signed [COMP_WIDTH-1:0]   a_n2,
  input  logic signed [COMP_WIDTH-1:0]   b_n2,
  input  logic signed [COMP_WIDTH-1:0]   s,
  output logic signed [2*COMP_WIDTH-1:0] p_ab,
  output logic signed [2*COMP_WIDTH-1:0] p_as,
  output logic signed [2*COMP_WIDTH-1:0] p_aa,
  output logic signed [2*COMP_WIDTH-1:0] p_bb,
  output logic signed [2*COMP_WIDTH-1:0] p_c0,
  output logic signed [2*COMP_WIDTH-1:0] p_c1
);

  always_ff @(posedge clk) begin
    if (en) begin
      p_ab <= a * b;
      p_as <= a * s;
      p_aa <= a * a;
      p_bb <= b * b;
      p_c0 <= a_n1 * b_n2;   // cross term, minuend
      p_c1 <= a_n2 * b_n1;   // cross term, subtrahend
    end
  end

endmodule

`default_nettype wire

>>> design/vmu_isqrt.sv
// Pipelined floor square root, one result bit per stage.
`default_nettype none

module vmu_isqrt import vmu_pkg::*; #(
  parameter int IN_W = 2 * COMP_WIDTH_DEF + 2
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   op,
  output logic [IN_W/2-1:0] root
);

  localparam int R  = IN_W / 2;
  localparam int RW = R + 3;

  logic [RW-1:0]   rem_q  [R];
  logic [R-1:0]    root_q [R];
  logic [IN_W-1:0] op_q   [R];

  for (genvar j = 0; j < R; j++) begin : g_stage
    logic [RW-1:0]   rem_i;
    logic [R-1:0]    root_i;
    logic [IN_W-1:0] op_i;
    logic [RW-1:0]   cur;
    logic [RW-1:0]   trial;

    if (j == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign op_i   = op;
    end else begin : g_next
      assign rem_i  = rem_q[j-1];
      assign root_i = root_q[j-1];
      assign op_i   = op_q[j-1];
    end

    assign cur   = {rem_i[RW-3:0], op_i[IN_W-1 -: 2]};
    assign trial = RW'({root_i, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem_q[j]  <= cur - trial;
          root_q[j] <= {root_i[R-2:0], 1'b1};
        end else begin
          rem_q[j]  <= cur;
          root_q[j] <= {root_i[R-2:0], 1'b0};
        end
        op_q[j] <= op_i << 2;
      end
    end
  end

  assign root = root_q[R-1];

endmodule

`default_nettype wire

>>> design/vmu_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
`default_nettype none

module vmu_div import vmu_pkg::*; #(
  parameter int NUM_W = COMP_WIDTH_DEF + FRAC_BITS_DEF,
  parameter int DEN_W = 2 * COMP_WIDTH_DEF + 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic             neg_in,
  output logic [NUM_W-1:0] quo,
  output logic             neg_out
);

  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] qn_q  [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic             neg_q [NUM_W];

  for (genvar j = 0; j < NUM_W; j++) begin : g_stage
    logic [DEN_W-1:0] rem_i;
    logic [NUM_W-1:0] qn_i;
    logic [DEN_W-1:0] den_i;
    logic             neg_i;
    logic [DEN_W:0]   cur;

    if (j == 0) begin : g_first
      assign rem_i = '0;
      assign qn_i  = num;
      assign den_i = den;
      assign neg_i = neg_in;
    end else begin : g_next
      assign rem_i = rem_q[j-1];
      assign qn_i  = qn_q[j-1];
      assign den_i = den_q[j-1];
      assign neg_i = neg_q[j-1];
    end

    assign cur = {rem_i, qn_i[NUM_W-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= {1'b0, den_i}) begin
          rem_q[j] <= DEN_W'(cur - {1'b0, den_i});
          qn_q[j]  <= {qn_i[NUM_W-2:0], 1'b1};
        end else begin
          rem_q[j] <= cur[DEN_W-1:0];
          qn_q[j]  <= {qn_i[NUM_W-2:0], 1'b0};
        end
        den_q[j] <= den_i;
        neg_q[j] <= neg_i;
      end
    end
  end

  assign quo     = qn_q[NUM_W-1];
  assign neg_out = neg_q[NUM_W-1];

endmodule

`default_nettype wire

>>> design/vector3_math_unit_core.sv
// Top level of the 3D vector math unit: lanes, merge, sqrt, dividers, result.
//
//   channel | dir | payload                                  | transfer when
//   --------+-----+------------------------------------------+------------------
//   req     | in  | cmd, a_x..a_z, b_x..b_z, scalar_in       | valid && ready
//   rsp     | out | res_x, res_y, res_z, res_scalar, status  | valid && ready
//
// Fully pipelined: one transfer in and one out per cycle while rsp does not
// stall; components are Q16.16 by default. The path runs through the
// (COMP_WIDTH+1)-stage square root followed by the (COMP_WIDTH+FRAC_BITS)-stage
// dividers. Every opcode takes the same path, so results leave in order.
// A stall on rsp freezes the whole pipe; req.ready drops only while the
// output register holds a result that is not taken. Sync reset clears the
// valid bits only; datapath registers are not reset.
`default_nettype none

module vector3_math_unit_core import vmu_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  vmu_req_if.sink    req,
  vmu_rsp_if.source  rsp
);

  localparam int W   = COMP_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;          // full product
  localparam int SW  = 2 * W + 2;      // exact sum of three squares
  localparam int R   = W + 1;          // square root width
  localparam int NW  = W + F;          // dividend width, scaled by 2^F
  localparam int MPW = SW - F;         // |b|^2 brought down to F fraction bits
  localparam int WX  = 2 * W + F + 4;  // headroom for every pre-saturation value
  localparam int LAT = 3 + R + NW + 2;

  localparam logic signed [WX-1:0] VMAX_X = $signed({{(WX-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [WX-1:0] VMIN_X = $signed({{(WX-W+1){1'b1}}, {(W-1){1'b0}}});

  // saturate to the component range; msb of the result is the clip flag
  function automatic logic [W:0] sat_f(input logic signed [WX-1:0] v);
    logic [W:0] r;
    if (v > VMAX_X) begin
      r = {1'b1, VMAX_X[W-1:0]};
    end else if (v < VMIN_X) begin
      r = {1'b1, VMIN_X[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  // sideband that rides alongside the sqrt and divider pipes
  typedef struct packed {
    logic [3:0]          cmd;
    logic [2:0][W-1:0]   a;
    logic [2:0][W-1:0]   b;
    logic [W-1:0]        s;
    logic [2:0][W-1:0]   vec;      // add/sub/cross/scale result, already clipped
    logic                vflag;
    logic [W-1:0]        dsc;      // clipped dot product
    logic                dflag;
    logic                s_zero;
    logic                sa_zero;
    logic                sb_zero;
    logic                mp_zero;
    logic [MPW-1:0]      mp;
    logic [R-1:0]        root;
  } sb_t;

  logic            en;
  logic [LAT-1:0]  vpipe;
  logic            o_valid;

  // stall-all pipe: advance whenever the output register can move
  assign en        = !o_valid || rsp.ready;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe   <= '0;
      o_valid <= 1'b0;
    end else if (en) begin
      vpipe   <= {vpipe[LAT-2:0], req.valid};
      o_valid <= vpipe[LAT-1];
    end
  end

  // ---------------------------------------------------------------- stage 1
  // three lanes form every product a component needs
  logic signed [W-1:0]  in_a [3];
  logic signed [W-1:0]  in_b [3];
  logic signed [PW-1:0] p_ab [3];
  logic signed [PW-1:0] p_as [3];
  logic signed [PW-1:0] p_aa [3];
  logic signed [PW-1:0] p_bb [3];
  logic signed [PW-1:0] p_c0 [3];
  logic signed [PW-1:0] p_c1 [3];

  assign in_a[0] = req.a_x;
  assign in_a[1] = req.a_y;
  assign in_a[2] = req.a_z;
  assign in_b[0] = req.b_x;
  assign in_b[1] = req.b_y;
  assign in_b[2] = req.b_z;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int N1 = (i + 1) % 3;
    localparam int N2 = (i + 2) % 3;
    vmu_lane #(.COMP_WIDTH(W)) u_lane (
      .clk  (clk),
      .en   (en),
      .a    (in_a[i]),
      .b    (in_b[i]),
      .a_n1 (in_a[N1]),
      .b_n1 (in_b[N1]),
      .a_n2 (in_a[N2]),
      .b_n2 (in_b[N2]),
      .s    (req.scalar_in),
      .p_ab (p_ab[i]),
      .p_as (p_as[i]),
      .p_aa (p_aa[i]),
      .p_bb (p_bb[i]),
      .p_c0 (p_c0[i]),
      .p_c1 (p_c1[i])
    );
  end

  logic [3:0]          st1_cmd;
  logic signed [W-1:0] st1_a [3];
  logic signed [W-1:0] st1_b [3];
  logic signed [W-1:0] st1_s;

  always_ff @(posedge clk) begin
    if (en) begin
      st1_cmd <= req.cmd;
      st1_a   <= in_a;
      st1_b   <= in_b;
      st1_s   <= req.scalar_in;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // merge: floor-shift the products, sum across lanes, pick the vector op
  logic signed [PW-1:0] sh_ab [3];
  logic signed [PW-1:0] sh_as [3];
  logic signed [PW-1:0] sh_c0 [3];
  logic signed [PW-1:0] sh_c1 [3];
  logic signed [WX-1:0] vraw2 [3];
  logic signed [WX-1:0] dot2;
  logic [SW-1:0]        ssa2;
  logic [SW-1:0]        ssb2;

  always_comb begin
    dot2 = '0;
    ssa2 = '0;
    ssb2 = '0;
    for (int i = 0; i < 3; i++) begin
      sh_ab[i] = p_ab[i] >>> F;
      sh_as[i] = p_as[i] >>> F;
      sh_c0[i] = p_c0[i] >>> F;
      sh_c1[i] = p_c1[i] >>> F;
      dot2     = dot2 + WX'(sh_ab[i]);
      ssa2     = ssa2 + SW'($unsigned(p_aa[i]));
      ssb2     = ssb2 + SW'($unsigned(p_bb[i]));
      unique case (st1_cmd)
        OP_ADD:   vraw2[i] = WX'(st1_a[i]) + WX'(st1_b[i]);
        OP_SUB:   vraw2[i] = WX'(st1_a[i]) - WX'(st1_b[i]);
        OP_CROSS: vraw2[i] = WX'(sh_c0[i]) - WX'(sh_c1[i]);
        OP_SCALE: vraw2[i] = WX'(sh_as[i]);
        default:  vraw2[i] = '0;
      endcase
    end
  end

  logic [3:0]           st2_cmd;
  logic signed [W-1:0]  st2_a [3];
  logic signed [W-1:0]  st2_b [3];
  logic signed [W-1:0]  st2_s;
  logic signed [WX-1:0] st2_vraw [3];
  logic signed [WX-1:0] st2_dot;
  logic [SW-1:0]        st2_ssa;
  logic [SW-1:0]        st2_ssb;

  always_ff @(posedge clk) begin
    if (en) begin
      st2_cmd  <= st1_cmd;
      st2_a    <= st1_a;
      st2_b    <= st1_b;
      st2_s    <= st1_s;
      st2_vraw <= vraw2;
      st2_dot  <= dot2;
      st2_ssa  <= ssa2;
      st2_ssb  <= ssb2;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // clip the simple results, note the zero cases, choose the sqrt operand
  sb_t        sb3;
  logic [W:0] vs3 [3];
  logic [W:0] ds3;

  always_comb begin
    ds3         = sat_f(st2_dot);
    sb3         = '0;
    sb3.cmd     = st2_cmd;
    sb3.s       = st2_s;
    sb3.dsc     = ds3[W-1:0];
    sb3.dflag   = ds3[W];
    for (int i = 0; i < 3; i++) begin
      vs3[i]     = sat_f(st2_vraw[i]);
      sb3.a[i]   = st2_a[i];
      sb3.b[i]   = st2_b[i];
      sb3.vec[i] = vs3[i][W-1:0];
    end
    sb3.vflag   = vs3[0][W] | vs3[1][W] | vs3[2][W];
    sb3.s_zero  = (st2_s == '0);
    sb3.sa_zero = (st2_ssa == '0);
    sb3.sb_zero = (st2_ssb == '0);
    sb3.mp      = st2_ssb[SW-1:F];
    sb3.mp_zero = (st2_ssb[SW-1:F] == '0);
  end

  sb_t           sb3q;
  logic [SW-1:0] sq_op;

  always_ff @(posedge clk) begin
    if (en) begin
      sb3q  <= sb3;
      sq_op <= (st2_cmd == OP_SPROJ) ? st2_ssb : st2_ssa;
    end
  end

  // ---------------------------------------------------------------- square root
  logic [R-1:0] root;
  sb_t          sbq [R];

  vmu_isqrt #(.IN_W(SW)) u_isqrt (
    .clk  (clk),
    .en   (en),
    .op   (sq_op),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sbq[0] <= sb3q;
      for (int j = 1; j < R; j++) begin
        sbq[j] <= sbq[j-1];
      end
    end
  end

  // ---------------------------------------------------------------- dividers
  // signs are split off; the dividers work on magnitudes
  sb_t                 sbr;
  logic signed [W-1:0] nv   [3];
  logic [W-1:0]        nmag [3];
  logic [SW-1:0]       dmag [3];
  logic                dneg [3];
  logic [NW-1:0]       dnum [3];
  logic                dsgn [3];
  logic [W-1:0]        s_mag;

  always_comb begin
    sbr      = sbq[R-1];
    sbr.root = root;
    s_mag    = sbr.s[W-1] ? W'(-$signed(sbr.s)) : sbr.s;
    for (int i = 0; i < 3; i++) begin
      unique case (sbr.cmd)
        OP_DIV: begin
          nv[i]   = $signed(sbr.a[i]);
          dmag[i] = SW'(s_mag);
          dneg[i] = sbr.s[W-1];
        end
        OP_NORM: begin
          nv[i]   = $signed(sbr.a[i]);
          dmag[i] = SW'(root);
          dneg[i] = 1'b0;
        end
        OP_PROJ: begin
          nv[i]   = $signed(sbr.dsc);
          dmag[i] = SW'(sbr.mp);
          dneg[i] = 1'b0;
        end
        OP_SPROJ: begin
          nv[i]   = $signed(sbr.dsc);
          dmag[i] = SW'(root);
          dneg[i] = 1'b0;
        end
        default: begin
          nv[i]   = '0;
          dmag[i] = '0;
          dneg[i] = 1'b0;
        end
      endcase
      nmag[i] = nv[i][W-1] ? W'(-nv[i]) : W'(nv[i]);
      dnum[i] = {nmag[i], {F{1'b0}}};
      dsgn[i] = nv[i][W-1] ^ dneg[i];
    end
  end

  logic [NW-1:0] quo  [3];
  logic          qneg [3];
  sb_t           sbd  [NW];

  for (genvar i = 0; i < 3; i++) begin : g_div
    vmu_div #(.NUM_W(NW), .DEN_W(SW)) u_div (
      .clk     (clk),
      .en      (en),
      .num     (dnum[i]),
      .den     (dmag[i]),
      .neg_in  (dsgn[i]),
      .quo     (quo[i]),
      .neg_out (qneg[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbd[0] <= sbr;
      for (int j = 1; j < NW; j++) begin
        sbd[j] <= sbd[j-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage E
  // restore the quotient sign (truncation toward zero) and clip
  logic signed [WX-1:0] qx [3];
  logic [W:0]           qs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qx[i] = qneg[i] ? -$signed(WX'(quo[i])) : $signed(WX'(quo[i]));
      qs[i] = sat_f(qx[i]);
    end
  end

  sb_t          sbe;
  logic [W-1:0] e_q  [3];
  logic         e_qf [3];

  always_ff @(posedge clk) begin
    if (en) begin
      sbe <= sbd[NW-1];
      for (int i = 0; i < 3; i++) begin
        e_q[i]  <= qs[i][W-1:0];
        e_qf[i] <= qs[i][W];
      end
    end
  end

  // ---------------------------------------------------------------- stage F
  // projection: b scaled by the clipped coefficient in lane 0
  sb_t                  sbf;
  logic [W-1:0]         f_q  [3];
  logic                 f_qf [3];
  logic signed [PW-1:0] f_prod [3];

  always_ff @(posedge clk) begin
    if (en) begin
      sbf  <= sbe;
      f_q  <= e_q;
      f_qf <= e_qf;
      for (int i = 0; i < 3; i++) begin
        f_prod[i] <= $signed(sbe.b[i]) * $signed(e_q[0]);
      end
    end
  end

  // ---------------------------------------------------------------- result
  logic [W-1:0]         g_res [3];
  logic [W-1:0]         g_sc;
  logic                 g_flag;
  logic                 g_divz;
  logic [1:0]           g_st;
  logic [W:0]           g_mag;
  logic signed [PW-1:0] g_psh [3];
  logic [W:0]           g_pr  [3];

  always_comb begin
    g_mag = sat_f(WX'(sbf.root));
    for (int i = 0; i < 3; i++) begin
      g_psh[i] = f_prod[i] >>> F;
      g_pr[i]  = sat_f(WX'(g_psh[i]));
      g_res[i] = '0;
    end
    g_sc   = '0;
    g_flag = 1'b0;
    g_divz = 1'b0;
    unique case (sbf.cmd) inside
      OP_ADD, OP_SUB, OP_CROSS, OP_SCALE: begin
        for (int i = 0; i < 3; i++) g_res[i] = sbf.vec[i];
        g_flag = sbf.vflag;
      end
      OP_DOT: begin
        g_sc   = sbf.dsc;
        g_flag = sbf.dflag;
      end
      OP_DIV: begin
        if (sbf.s_zero) begin
          g_divz = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) g_res[i] = f_q[i];
          g_flag = f_qf[0] | f_qf[1] | f_qf[2];
        end
      end
      OP_MAG: begin
        g_sc   = g_mag[W-1:0];
        g_flag = g_mag[W];
      end
      OP_NORM: begin
        // zero vector normalises to zero, status ok
        if (!sbf.sa_zero) begin
          for (int i = 0; i < 3; i++) g_res[i] = f_q[i];
          g_flag = f_qf[0] | f_qf[1] | f_qf[2];
        end
      end
      OP_PROJ: begin
        if (sbf.mp_zero) begin
          g_divz = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) g_res[i] = g_pr[i][W-1:0];
          g_flag = sbf.dflag | f_qf[0] | g_pr[0][W] | g_pr[1][W] | g_pr[2][W];
        end
      end
      OP_SPROJ: begin
        if (sbf.sb_zero) begin
          g_divz = 1'b1;
        end else begin
          g_sc   = f_q[0];
          g_flag = sbf.dflag | f_qf[0];
        end
      end
      default: begin
        g_flag = 1'b0;
      end
    endcase
    // divide by zero outranks saturation
    if (g_divz) begin
      g_st = ST_DIVZ;
    end else if (g_flag) begin
      g_st = ST_SAT;
    end else begin
      g_st = ST_OK;
    end
  end

  logic [W-1:0] o_x;
  logic [W-1:0] o_y;
  logic [W-1:0] o_z;
  logic [W-1:0] o_sc;
  logic [1:0]   o_st;

  always_ff @(posedge clk) begin
    if (en) begin
      o_x  <= g_res[0];
      o_y  <= g_res[1];
      o_z  <= g_res[2];
      o_sc <= g_sc;
      o_st <= g_st;
    end
  end

  assign rsp.valid      = o_valid;
  assign rsp.res_x      = $signed(o_x);
  assign rsp.res_y      = $signed(o_y);
  assign rsp.res_z      = $signed(o_z);
  assign rsp.res_scalar = $signed(o_sc);
  assign rsp.status     = o_st;

endmodule

`default_nettype wire

>>> sim/tb_vector3_math_unit_core.sv
// Self-checking testbench for the 3D vector math unit: directed and random ops, scoreboarded.
`default_nettype none

module tb_vector3_math_unit_core import vmu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CW      = COMP_WIDTH_DEF;
  localparam int     FB      = FRAC_BITS_DEF;
  localparam longint VEC_MAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint VEC_MIN = -VEC_MAX - 1;
  localparam longint Q_ONE   = longint'(1) <<< FB;
  // drain margin on top of the pipe depth at Q16.16
  localparam int     DRAIN   = 2 * CW + FB + 40;

  typedef struct {
    logic [3:0]           cmd;
    logic signed [CW-1:0] a [3];
    logic signed [CW-1:0] b [3];
    logic signed [CW-1:0] s;
  } vec_op_t;

  typedef struct {
    logic [CW-1:0] x, y, z, sc;
    logic [1:0]    st;
  } vec_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vmu_req_if #(.COMP_WIDTH(CW)) req_ch ();
  vmu_rsp_if #(.COMP_WIDTH(CW)) rsp_ch ();

  vector3_math_unit_core #(.COMP_WIDTH(CW), .FRAC_BITS(FB)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #1 clk = ~clk;

  vec_op_t  op_queue [$];   // items waiting to be driven
  vec_res_t want_q [$];     // predicted results, oldest first
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  send_hold     = 1'b0;
  bit  req_took      = 1'b0;
  int  fail_cnt      = 0;
  int  checked_cnt   = 0;
  int  op_cnt [16];

  // ---------------------------------------------------------------------
  // Predictor: fixed-point behaviour of the unit, computed in 64 bits
  // ---------------------------------------------------------------------
  function automatic longint clamp(longint v, inout bit hit);
    if (v > VEC_MAX) begin
      hit = 1'b1;
      return VEC_MAX;
    end
    if (v < VEC_MIN) begin
      hit = 1'b1;
      return VEC_MIN;
    end
    return v;
  endfunction

  // truncated Q product: arithmetic shift right gives floor
  function automatic longint qmul(longint x, longint y);
    return (x * y) >>> FB;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned sum_sq(longint v [3]);
    return longint'(v[0] * v[0]) + longint'(v[1] * v[1]) + longint'(v[2] * v[2]);
  endfunction

  function automatic vec_res_t predict_vec_op(vec_op_t it);
    longint          a [3];
    longint          b [3];
    longint          r [3];
    longint          s, dp, k, sc;
    longint unsigned sq, m;
    bit              hit;
    logic [1:0]      st;
    vec_res_t        res;
    for (int i = 0; i < 3; i++) begin
      a[i] = it.a[i];
      b[i] = it.b[i];
      r[i] = 0;
    end
    s   = it.s;
    sc  = 0;
    hit = 1'b0;
    st  = ST_OK;
    dp  = qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]);
    case (it.cmd)
      OP_ADD:   for (int i = 0; i < 3; i++) r[i] = clamp(a[i] + b[i], hit);
      OP_SUB:   for (int i = 0; i < 3; i++) r[i] = clamp(a[i] - b[i], hit);
      OP_DOT:   sc = clamp(dp, hit);
      OP_CROSS: begin
        r[0] = clamp(qmul(a[1], b[2]) - qmul(a[2], b[1]), hit);
        r[1] = clamp(qmul(a[2], b[0]) - qmul(a[0], b[2]), hit);
        r[2] = clamp(qmul(a[0], b[1]) - qmul(a[1], b[0]), hit);
      end
      OP_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp(qmul(a[i], s), hit);
      OP_DIV: begin
        if (s == 0) st = ST_DIVZ;
        else for (int i = 0; i < 3; i++) r[i] = clamp((a[i] * Q_ONE) / s, hit);
      end
      OP_MAG:   sc = clamp(longint'(floor_sqrt(sum_sq(a))), hit);
      OP_NORM: begin
        sq = sum_sq(a);
        if (sq != 0) begin
          m = floor_sqrt(sq);
          for (int i = 0; i < 3; i++) r[i] = clamp((a[i] * Q_ONE) / longint'(m), hit);
        end
      end
      OP_PROJ: begin
        dp = clamp(dp, hit);
        m  = sum_sq(b) >> FB;
        if (m == 0) st = ST_DIVZ;
        else begin
          k = clamp((dp * Q_ONE) / longint'(m), hit);
          for (int i = 0; i < 3; i++) r[i] = clamp(qmul(b[i], k), hit);
        end
      end
      OP_SPROJ: begin
        dp = clamp(dp, hit);
        sq = sum_sq(b);
        if (sq == 0) st = ST_DIVZ;
        else sc = clamp((dp * Q_ONE) / longint'(floor_sqrt(sq)), hit);
      end
      default: ;  // undefined opcodes: zeros, ok
    endcase
    if (st == ST_DIVZ) begin
      r[0] = 0; r[1] = 0; r[2] = 0; sc = 0;   // div-by-zero beats saturation
    end else if (hit) begin
      st = ST_SAT;
    end
    res.x  = r[0][CW-1:0];
    res.y  = r[1][CW-1:0];
    res.z  = r[2][CW-1:0];
    res.sc = sc[CW-1:0];
    res.st = st;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(0, 4))
      0: return CW'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      1: return CW'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      2: return $urandom();
      3: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return '1;
          2: return CW'(Q_ONE);
          3: return CW'(VEC_MAX);
          4: return CW'(VEC_MIN);
          default: return CW'(1);
        endcase
      end
      default: return CW'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  task automatic push_op(input logic [3:0] c, input longint ax, ay, az,
                         input longint bx, by, bz, input longint sv);
    vec_op_t it;
    it.cmd  = c;
    it.a[0] = ax[CW-1:0]; it.a[1] = ay[CW-1:0]; it.a[2] = az[CW-1:0];
    it.b[0] = bx[CW-1:0]; it.b[1] = by[CW-1:0]; it.b[2] = bz[CW-1:0];
    it.s    = sv[CW-1:0];
    op_queue.push_back(it);
  endtask

  task automatic push_random(input int n);
    vec_op_t it;
    for (int j = 0; j < n; j++) begin
      // mostly legal opcodes, a few undefined ones
      it.cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                            : 4'($urandom_range(0, 9));
      for (int i = 0; i < 3; i++) begin
        it.a[i] = rand_comp();
        it.b[i] = rand_comp();
      end
      it.s = rand_comp();
      // occasionally zero the divisor, or b up to its z lsb, to hit the divide-by-zero paths
      if ($urandom_range(0, 15) == 0) it.s = '0;
      if ($urandom_range(0, 15) == 0) begin
        it.b[0] = '0; it.b[1] = '0; it.b[2] = $urandom_range(0, 1);
      end
      op_queue.push_back(it);
    end
  endtask

  task automatic wait_sent();
    while (op_queue.size() != 0 || req_ch.valid) @(posedge clk);
  endtask

  task automatic wait_drained();
    while (want_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Request driver: new item on the falling edge once the last one is taken
  // ---------------------------------------------------------------------
  initial begin
    req_ch.valid = 1'b0;
    req_ch.cmd   = '0;
    req_ch.a_x = '0; req_ch.a_y = '0; req_ch.a_z = '0;
    req_ch.b_x = '0; req_ch.b_y = '0; req_ch.b_z = '0;
    req_ch.scalar_in = '0;
    rsp_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    vec_op_t it;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_took) begin
      if (!send_hold && op_queue.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        it = op_queue.pop_front();
        req_ch.cmd       <= it.cmd;
        req_ch.a_x       <= it.a[0];
        req_ch.a_y       <= it.a[1];
        req_ch.a_z       <= it.a[2];
        req_ch.b_x       <= it.b[0];
        req_ch.b_y       <= it.b[1];
        req_ch.b_z       <= it.b[2];
        req_ch.scalar_in <= it.s;
        req_ch.valid     <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response back-pressure
  always @(negedge clk) begin
    rsp_ch.ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------
  // Monitor: predict on each request transfer, check each response transfer
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    vec_op_t  it;
    vec_res_t want;
    req_took <= !rst && req_ch.valid && req_ch.ready;
    if (!rst && req_ch.valid && req_ch.ready) begin
      it.cmd  = req_ch.cmd;
      it.a[0] = req_ch.a_x; it.a[1] = req_ch.a_y; it.a[2] = req_ch.a_z;
      it.b[0] = req_ch.b_x; it.b[1] = req_ch.b_y; it.b[2] = req_ch.b_z;
      it.s    = req_ch.scalar_in;
      want_q.push_back(predict_vec_op(it));
      op_cnt[it.cmd]++;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (want_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected result transfer x=%h y=%h z=%h s=%h st=%0d", $time,
                 rsp_ch.res_x, rsp_ch.res_y, rsp_ch.res_z, rsp_ch.res_scalar, rsp_ch.status);
      end else begin
        want = want_q.pop_front();
        checked_cnt++;
        if (rsp_ch.res_x !== want.x || rsp_ch.res_y !== want.y ||
            rsp_ch.res_z !== want.z || rsp_ch.res_scalar !== want.sc ||
            rsp_ch.status !== want.st) begin
          fail_cnt++;
          $display("%0t: mismatch exp x=%h y=%h z=%h s=%h st=%0d got x=%h y=%h z=%h s=%h st=%0d",
                   $time, want.x, want.y, want.z, want.sc, want.st,
                   rsp_ch.res_x, rsp_ch.res_y, rsp_ch.res_z, rsp_ch.res_scalar,
                   rsp_ch.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: reset, directed corners, then three random phases
  // ---------------------------------------------------------------------
  initial begin
    int ops_used;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // one of every opcode plus the extremes
    push_op(OP_ADD,   VEC_MAX, VEC_MIN, 5, 1, -1, -7, 0);
    push_op(OP_SUB,   VEC_MIN, VEC_MAX, -1, 1, -1, -1, 0);
    push_op(OP_DOT,   Q_ONE, 2 * Q_ONE, -3 * Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0);
    push_op(OP_DOT,   VEC_MAX, VEC_MAX, VEC_MAX, VEC_MAX, VEC_MAX, VEC_MAX, -1);
    push_op(OP_CROSS, Q_ONE, 0, 0, 0, Q_ONE, 0, 0);
    push_op(OP_CROSS, VEC_MIN, VEC_MAX, VEC_MIN, VEC_MAX, VEC_MIN, VEC_MAX, 0);
    push_op(OP_SCALE, Q_ONE, -Q_ONE, 3, 0, 0, 0, -Q_ONE / 2);
    push_op(OP_SCALE, VEC_MAX, VEC_MIN, -1, 0, 0, 0, VEC_MAX);
    push_op(OP_DIV,   3 * Q_ONE, -Q_ONE, 7, 0, 0, 0, 2 * Q_ONE);
    push_op(OP_DIV,   VEC_MAX, VEC_MIN, 1, 0, 0, 0, 1);
    // divide by zero, with saturating operands too
    push_op(OP_DIV,   VEC_MAX, VEC_MIN, VEC_MAX, 0, 0, 0, 0);
    push_op(OP_MAG,   3 * Q_ONE, 4 * Q_ONE, 0, 0, 0, 0, 0);
    push_op(OP_MAG,   VEC_MIN, VEC_MIN, VEC_MIN, 0, 0, 0, 0);
    push_op(OP_NORM,  3 * Q_ONE, -4 * Q_ONE, 0, 0, 0, 0, 0);
    push_op(OP_NORM,  0, 0, 0, 0, 0, 0, 0);          // zero vector
    push_op(OP_NORM,  1, 0, -1, 0, 0, 0, 0);
    push_op(OP_PROJ,  Q_ONE, Q_ONE, 0, 2 * Q_ONE, 0, 0, 0);
    push_op(OP_PROJ,  Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 0);  // zero b
    push_op(OP_PROJ,  VEC_MAX, VEC_MAX, VEC_MAX, 1, 1, 1, 0);  // |b|^2 truncates away
    push_op(OP_PROJ,  VEC_MAX, VEC_MAX, VEC_MAX, 300, 0, 0, 0);
    push_op(OP_SPROJ, 2 * Q_ONE, 5, 0, 0, 3 * Q_ONE, 0, 0);
    push_op(OP_SPROJ, VEC_MAX, VEC_MAX, 0, 0, 0, 0, 0);  // zero b
    push_op(OP_SPROJ, VEC_MAX, VEC_MAX, VEC_MAX, 1, 0, 0, 0);
    push_op(4'd10, 1, 2, 3, 4, 5, 6, 7);
    push_op(4'd15, -1, -1, -1, -1, -1, -1, -1);

    // phase 1: sender idles a little, receiver a lot
    send_idle_pct = 16;
    recv_idle_pct = 45;
    push_random(130);
    wait_sent();

    // phase 2: roles swapped, with a full drain pause in the middle
    send_idle_pct = 45;
    recv_idle_pct = 16;
    push_random(60);
    wait_sent();
    send_hold = 1'b1;
    wait_drained();
    send_hold = 1'b0;
    push_random(70);
    wait_sent();

    // phase 3: back-to-back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(130);
    wait_sent();

    wait_drained();
    repeat (DRAIN) @(posedge clk);

    ops_used = 0;
    foreach (op_cnt[i]) if (op_cnt[i] != 0) ops_used++;
    $display("Checked %0d results over %0d distinct opcodes, %0d still outstanding",
             checked_cnt, ops_used, want_q.size());
    $display("Covered saturation, divide-by-zero and undefined opcodes under back-pressure");
    if (fail_cnt == 0 && want_q.size() == 0) begin
      $display("PASS vector3_math_unit_core");
    end else begin
      $display("FAIL vector3_math_unit_core");
    end
    $finish;
  end

  // watchdog
  initial begin
    #500000;
    $display("FAIL vector3_math_unit_core");
    $finish;
  end

endmodule

`default_nettype wire
